// File: design/mpt_pkg.sv
// mpt_pkg: types, codes and fixed widths shared by the priority table design
// no dependencies; compiled first

package mpt_pkg;

  localparam int MAC_W   = 48;
  localparam int CNT_W   = 16;
  localparam int TS_W    = 32;
  localparam int PRIO_W  = 49;
  localparam int WGT_W   = 16;
  localparam int ENT_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WEIGHT  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [MAC_W-1:0]         mac;
    logic [CNT_W-1:0]         cnt;
    logic [TS_W-1:0]          ts;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_MUL1, S_MUL2, S_SUM, S_PEEK, S_MERGE, S_TAIL, S_RESP
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       srch_step;
    logic       mul1;
    logic       mul2;
    logic       sum;
    logic       cap_top;
    logic       merge_start;
    logic       merge_step;
    logic       tail;
    logic       resp;
    logic       set_empty;
    logic       set_full;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       occ_zero;
    logic       full;
    logic       match;
    logic       srch_last;
    logic       merge_last;
  } sts_t;

endpackage

// File: design/mpt_if.sv
// mpt_in_if / mpt_out_if: valid-ready channels for requests and results
// depends on mpt_pkg for field widths

interface mpt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [mpt_pkg::MAC_W-1:0]   mac;
  logic [mpt_pkg::TS_W-1:0]    timestamp;
  modport source (output valid, req_type, mac, timestamp, input ready);
  modport sink   (input valid, req_type, mac, timestamp, output ready);
endinterface

interface mpt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [mpt_pkg::MAC_W-1:0]   mac_out;
  logic [mpt_pkg::ENT_W-1:0]   entries;
  modport source (output valid, status, mac_out, entries, input ready);
  modport sink   (input valid, status, mac_out, entries, output ready);
endinterface

// File: design/mpt_ram.sv
// mpt_ram: generic single write port, single read port ram, registered read
// no dependencies

module mpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mpt_ctrl.sv
// mpt_ctrl: request sequencer for the priority table
// depends on mpt_pkg; drives commands to mpt_dp

module mpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_req,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mpt_pkg::sts_t  sts,
  output mpt_pkg::cmd_t  cmd
);

  mpt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      mpt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_req)
            mpt_pkg::REQ_ENQ: state_nxt = mpt_pkg::S_SRCH;
            mpt_pkg::REQ_DEQ, mpt_pkg::REQ_PEEK: begin
              if (sts.occ_zero) begin
                cmd.set_empty = 1'b1;
                state_nxt     = mpt_pkg::S_RESP;
              end else begin
                state_nxt = mpt_pkg::S_PEEK;
              end
            end
            default: state_nxt = mpt_pkg::S_RESP;
          endcase
        end
      end
      mpt_pkg::S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_last) begin
          state_nxt = mpt_pkg::S_MUL1;
        end
      end
      mpt_pkg::S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = mpt_pkg::S_MUL2;
      end
      mpt_pkg::S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = mpt_pkg::S_SUM;
      end
      mpt_pkg::S_SUM: begin
        cmd.sum = 1'b1;
        if (!sts.match && sts.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = mpt_pkg::S_RESP;
        end else begin
          cmd.merge_start = 1'b1;
          state_nxt       = mpt_pkg::S_MERGE;
        end
      end
      mpt_pkg::S_PEEK: begin
        cmd.cap_top = 1'b1;
        if (sts.req == mpt_pkg::REQ_DEQ) begin
          cmd.merge_start = 1'b1;
          state_nxt       = mpt_pkg::S_MERGE;
        end else begin
          state_nxt = mpt_pkg::S_RESP;
        end
      end
      mpt_pkg::S_MERGE: begin
        cmd.merge_step = 1'b1;
        if (sts.merge_last) begin
          state_nxt = mpt_pkg::S_TAIL;
        end
      end
      mpt_pkg::S_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = mpt_pkg::S_RESP;
      end
      mpt_pkg::S_RESP: begin
        cmd.resp  = 1'b1;
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = mpt_pkg::S_IDLE;
        end
      end
      default: state_nxt = mpt_pkg::S_IDLE;
    endcase
  end

endmodule

// File: design/mpt_dp.sv
// mpt_dp: table datapath, two ram banks copied one into the other per update
// depends on mpt_pkg and mpt_ram

module mpt_dp #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mpt_pkg::cmd_t                   cmd,
  output mpt_pkg::sts_t                   sts,
  input  logic [1:0]                      in_req,
  input  logic [mpt_pkg::MAC_W-1:0]       in_mac,
  input  logic [mpt_pkg::TS_W-1:0]        in_ts,
  input  logic                            cfg_we,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mpt_pkg::WGT_W-1:0]       cfg_data,
  output logic [1:0]                      res_status,
  output logic [mpt_pkg::MAC_W-1:0]       res_mac,
  output logic [mpt_pkg::ENT_W-1:0]       res_entries
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_OCC = CW'(MAX_ENTRIES);

  logic                        bank_r;
  logic [CW-1:0]               occ_r, idx_r, pos_r, widx_r, skip_r;
  logic                        dv_r, inserted_r, skip_en_r;
  logic                        match_r;
  logic [CW-1:0]               midx_r;
  logic [mpt_pkg::CNT_W-1:0]   mcnt_r, cnt_r;
  logic [1:0]                  req_r;
  logic [mpt_pkg::MAC_W-1:0]   mac_r;
  logic [mpt_pkg::TS_W-1:0]    ts_r;
  logic signed [mpt_pkg::WGT_W-1:0] cw_r, tw_r;
  logic signed [32:0]          pc_r;
  logic signed [48:0]          pt_r;
  mpt_pkg::entry_t             new_r;
  logic [1:0]                  status_r;
  logic [mpt_pkg::MAC_W-1:0]   rmac_r;

  mpt_pkg::entry_t             rd0, rd1, rdata, wdata;
  logic [AW-1:0]               raddr;
  logic                        we, stall, skip_hit;
  logic [CW+mpt_pkg::ENT_W-1:0] occ_ext;

  assign rdata    = bank_r ? rd1 : rd0;
  assign skip_hit = skip_en_r && (pos_r == skip_r);
  // new entry goes before the first lower priority entry
  assign stall    = cmd.merge_step && dv_r && !skip_hit && !inserted_r &&
                    ($signed(rdata.prio) < $signed(new_r.prio));
  assign raddr    = stall ? pos_r[AW-1:0] : idx_r[AW-1:0];
  assign we       = (cmd.merge_step && dv_r && !skip_hit) || (cmd.tail && !inserted_r);
  assign wdata    = (stall || cmd.tail) ? new_r : rdata;

  mpt_ram #(.WIDTH(mpt_pkg::ENTRY_W), .DEPTH(MAX_ENTRIES)) u_bank0 (
    .clk(clk), .we(we && bank_r), .waddr(widx_r[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rd0)
  );

  mpt_ram #(.WIDTH(mpt_pkg::ENTRY_W), .DEPTH(MAX_ENTRIES)) u_bank1 (
    .clk(clk), .we(we && !bank_r), .waddr(widx_r[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      occ_r    <= '0;
      idx_r    <= '0;
      dv_r     <= 1'b0;
      cw_r     <= mpt_pkg::WGT_W'(1);
      tw_r     <= '0;
      match_r  <= 1'b0;
      status_r <= mpt_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          mpt_pkg::CFG_COUNT_WEIGHT: cw_r <= cfg_data;
          mpt_pkg::CFG_TIME_WEIGHT:  tw_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        req_r    <= in_req;
        mac_r    <= in_mac;
        ts_r     <= in_ts;
        idx_r    <= '0;
        dv_r     <= 1'b0;
        match_r  <= 1'b0;
        status_r <= cmd.set_empty ? mpt_pkg::ST_EMPTY : mpt_pkg::ST_OK;
        rmac_r   <= '0;
      end
      if (cmd.set_full)  status_r <= mpt_pkg::ST_FULL;
      if (cmd.srch_step) begin
        idx_r <= idx_r + CW'(1);
        pos_r <= idx_r;
        dv_r  <= (idx_r < occ_r);
        if (dv_r && rdata.mac == mac_r) begin
          match_r <= 1'b1;
          midx_r  <= pos_r;
          mcnt_r  <= rdata.cnt;
        end
      end
      if (cmd.mul1) begin
        if (match_r) begin
          cnt_r <= (mcnt_r == mpt_pkg::CNT_MAX) ? mcnt_r : mcnt_r + 16'd1;
          pc_r  <= cw_r * $signed({1'b0, ((mcnt_r == mpt_pkg::CNT_MAX) ?
                                          mcnt_r : mcnt_r + 16'd1)});
        end else begin
          cnt_r <= 16'd1;
          pc_r  <= 33'(cw_r);
        end
      end
      if (cmd.mul2) begin
        pt_r <= tw_r * $signed({1'b0, ts_r});
      end
      if (cmd.sum) begin
        new_r.mac  <= mac_r;
        new_r.cnt  <= cnt_r;
        new_r.ts   <= ts_r;
        new_r.prio <= 49'(pc_r) + pt_r;
      end
      if (cmd.cap_top) begin
        rmac_r <= rdata.mac;
      end
      if (cmd.merge_start) begin
        idx_r      <= '0;
        dv_r       <= 1'b0;
        widx_r     <= '0;
        inserted_r <= (req_r == mpt_pkg::REQ_DEQ);
        skip_en_r  <= match_r || (req_r == mpt_pkg::REQ_DEQ);
        skip_r     <= (req_r == mpt_pkg::REQ_DEQ) ? '0 : midx_r;
      end
      if (cmd.merge_step) begin
        if (stall) begin
          inserted_r <= 1'b1;
          idx_r      <= pos_r + CW'(1);
          dv_r       <= 1'b1;
        end else begin
          idx_r <= idx_r + CW'(1);
          pos_r <= idx_r;
          dv_r  <= (idx_r < occ_r);
        end
        if (we) widx_r <= widx_r + CW'(1);
      end
      if (cmd.tail) begin
        bank_r <= !bank_r;
        if (req_r == mpt_pkg::REQ_DEQ) begin
          occ_r <= occ_r - CW'(1);
        end else if (!match_r) begin
          occ_r <= occ_r + CW'(1);
        end
      end
      if (cmd.resp) begin
        idx_r <= '0;
        dv_r  <= 1'b0;
      end
    end
  end

  assign occ_ext = {{mpt_pkg::ENT_W{1'b0}}, occ_r};

  always_comb begin
    sts.req        = req_r;
    sts.occ_zero   = (occ_r == '0);
    sts.full       = (occ_r >= MAX_OCC);
    sts.match      = match_r;
    sts.srch_last  = (idx_r == occ_r);
    sts.merge_last = (occ_r == '0) ||
                     (dv_r && (pos_r == occ_r - CW'(1)) && !stall);
  end

  assign res_status  = status_r;
  assign res_mac     = rmac_r;
  assign res_entries = occ_ext[mpt_pkg::ENT_W-1:0];

endmodule

// File: design/mac_priority_table.sv
// mac_priority_table: top level joining the request sequencer and the table datapath
// depends on mpt_pkg, mpt_if, mpt_ctrl, mpt_dp (which uses mpt_ram)
//
// Requests arrive on in_ch (enqueue, dequeue, peek) and each gives exactly one
// result item on out_ch with a status, the top address for dequeue and peek,
// and the occupancy after the request. The weights must be written on the cfg
// port only while the block is idle; the block itself does not enforce this.
// One request is worked at a time; in_ch is ready only while idle. A peek
// captures the address of the top entry, then gives its result. An enqueue
// scans the table for the address, forms the two weight products and their
// sum and, unless the table is full without the address, copies the table
// from one ram bank into the other while dropping the old copy and placing
// the new one. A dequeue copies the same way without the insertion.
// Reset empties the table and sets the weights to 1 and 0; no clearing pass.
// A result holds on out_ch until taken; while out_ch stalls no request is taken.

module mac_priority_table #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mpt_in_if.sink                            in_ch,
  mpt_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpt_pkg::WGT_W-1:0]         cfg_data
);

  mpt_pkg::cmd_t cmd;
  mpt_pkg::sts_t sts;

  mpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_req(in_ch.req_type), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  mpt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req(in_ch.req_type), .in_mac(in_ch.mac), .in_ts(in_ch.timestamp),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .res_status(out_ch.status), .res_mac(out_ch.mac_out),
    .res_entries(out_ch.entries)
  );

endmodule

// File: dv/mpt_tb_if.sv
`timescale 1ns / 100ps
// testbench side of the request and result channels
// the design interfaces mpt_in_if / mpt_out_if come from design/mpt_if.sv; nothing here

package mpt_tb_types;
  import mpt_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [MAC_W-1:0] mac_out;
    logic [ENT_W-1:0] entries;
  } result_t;
endpackage

// File: dv/mac_priority_table_tb.sv
`timescale 1ns / 100ps
// self-checking bench for mac_priority_table: random and directed requests,
// a priority table model in a scoreboard class, random idling on both channels
// depends on mpt_pkg, mpt_if, mpt_tb_if and the design files

module mac_priority_table_tb;
  import mpt_pkg::*;
  import mpt_tb_types::*;

  localparam int DEPTH = 64;

  class table_scoreboard;
    logic [MAC_W-1:0]         t_mac[DEPTH];
    logic [CNT_W-1:0]         t_cnt[DEPTH];
    logic signed [PRIO_W-1:0] t_prio[DEPTH];
    int                       occ;
    logic signed [WGT_W-1:0]  w_count;
    logic signed [WGT_W-1:0]  w_time;
    result_t                  pending[$];
    int                       errors;

    function new();
      occ = 0;
      w_count = 1;
      w_time = 0;
      errors = 0;
    endfunction

    function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [WGT_W-1:0] val);
      if (idx == CFG_COUNT_WEIGHT) w_count = val;
      else w_time = val;
    endfunction

    function logic signed [PRIO_W-1:0] prio_of(logic [CNT_W-1:0] c, logic [TS_W-1:0] ts);
      longint p;
      p = longint'(w_count) * longint'({1'b0, c}) + longint'(w_time) * longint'({1'b0, ts});
      return p[PRIO_W-1:0];
    endfunction

    // drop slot pos and close the gap
    function void remove_slot(int pos);
      for (int i = pos; i + 1 < occ; i++) begin
        t_mac[i] = t_mac[i+1];
        t_cnt[i] = t_cnt[i+1];
        t_prio[i] = t_prio[i+1];
      end
      occ--;
    endfunction

    // insert behind every entry of greater or equal priority
    function void insert_sorted(logic [MAC_W-1:0] m, logic [CNT_W-1:0] c,
                                logic signed [PRIO_W-1:0] p);
      int pos;
      pos = 0;
      while (pos < occ && t_prio[pos] >= p) pos++;
      for (int i = occ; i > pos; i--) begin
        t_mac[i] = t_mac[i-1];
        t_cnt[i] = t_cnt[i-1];
        t_prio[i] = t_prio[i-1];
      end
      t_mac[pos] = m;
      t_cnt[pos] = c;
      t_prio[pos] = p;
      occ++;
    endfunction

    function void note_request(logic [1:0] req, logic [MAC_W-1:0] m, logic [TS_W-1:0] ts);
      result_t r;
      int hit;
      logic [CNT_W-1:0] c;
      r = '0;
      if (req == REQ_ENQ) begin
        hit = -1;
        for (int i = 0; i < occ; i++) if (hit < 0 && t_mac[i] == m) hit = i;
        if (hit >= 0) begin
          c = t_cnt[hit];
          if (c != CNT_MAX) c++;
          remove_slot(hit);
          insert_sorted(m, c, prio_of(c, ts));
        end else if (occ >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          insert_sorted(m, CNT_W'(1), prio_of(CNT_W'(1), ts));
        end
      end else if (req == REQ_DEQ || req == REQ_PEEK) begin
        if (occ == 0) r.status = ST_EMPTY;
        else begin
          r.mac_out = t_mac[0];
          if (req == REQ_DEQ) remove_slot(0);
        end
      end
      r.entries = occ[ENT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: status %0d mac %h", got.status, got.mac_out);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.mac_out !== e.mac_out) begin
        $error("mac_out: expected %h, got %h", e.mac_out, got.mac_out);
        errors++;
      end
      if (got.entries !== e.entries) begin
        $error("entries: expected %0d, got %0d", e.entries, got.entries);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WGT_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  mpt_in_if in_ch ();
  mpt_out_if out_ch ();

  mac_priority_table #(.MAX_ENTRIES(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  table_scoreboard sb = new();
  logic [MAC_W-1:0] mac_pool[16];

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_PEEK;
    in_ch.mac = '0;
    in_ch.timestamp = '0;
    out_ch.ready = 1'b0;
  end

  // result side: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.status, out_ch.mac_out, out_ch.entries});
  end

  // valid stays up after an item until the next idle cycle or drain
  task automatic send_request(logic [1:0] req, logic [MAC_W-1:0] m, logic [TS_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.mac <= m;
    in_ch.timestamp <= ts;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(req, m, ts);
    @(negedge clk);
  endtask

  task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [WGT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_weight(idx, val);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // mostly enqueues of a small address pool so that hits, ties and saturation occur
  task automatic random_phase(int n, int idle, int stall);
    int k;
    logic [1:0] req;
    logic [MAC_W-1:0] m;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) req = REQ_ENQ;
      else if (k < 75) req = REQ_DEQ;
      else if (k < 97) req = REQ_PEEK;
      else req = 2'd3;
      m = ($urandom_range(3) != 0) ? mac_pool[$urandom_range(15)] : rand_mac();
      send_request(req, m, ($urandom_range(3) == 0) ? $urandom : $urandom_range(15));
    end
    drain();
  endtask

  initial begin : stimulus
    logic [WGT_W-1:0] wc[5];
    logic [WGT_W-1:0] wt[5];
    for (int i = 0; i < 16; i++) mac_pool[i] = rand_mac();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, unused code, extremes of fields
    send_request(REQ_PEEK, '0, '0);
    send_request(REQ_DEQ, '1, '1);
    send_request(2'd3, '0, '0);
    send_request(REQ_ENQ, '0, '0);
    send_request(REQ_ENQ, '1, '1);
    send_request(REQ_ENQ, 48'h5555_5555_5555, 32'hAAAA_AAAA);
    send_request(REQ_ENQ, '1, '0);
    send_request(REQ_PEEK, '0, '0);
    send_request(2'd3, '1, '1);
    send_request(REQ_DEQ, '0, '0);
    send_request(REQ_DEQ, '0, '0);
    send_request(REQ_DEQ, '0, '0);
    send_request(REQ_DEQ, '0, '0);
    drain();

    // fill past capacity with timestamp-weighted priorities, then enqueue a pool address while full
    write_weight(CFG_TIME_WEIGHT, 16'sd1);
    for (int i = 0; i < DEPTH + 3; i++) send_request(REQ_ENQ, rand_mac(), $urandom);
    send_request(REQ_ENQ, mac_pool[0], 32'd7);
    drain();
    // long hold-off on results while requests keep coming
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_request(REQ_DEQ, '0, '0);
    drain();
    for (int i = 0; i < DEPTH; i++) send_request(REQ_DEQ, '0, '0);
    drain();

    // repeated hits on one address, first with zero weights, then count-weighted
    write_weight(CFG_COUNT_WEIGHT, 16'sd0);
    write_weight(CFG_TIME_WEIGHT, 16'sd0);
    for (int i = 0; i < 66; i++) send_request(REQ_ENQ, mac_pool[1], i);
    drain();
    write_weight(CFG_COUNT_WEIGHT, 16'sd1);
    for (int i = 0; i < 140; i++) send_request(REQ_ENQ, mac_pool[1], $urandom);
    send_request(REQ_DEQ, '0, '0);
    drain();

    wc = '{16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0003};
    wt = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};
    for (int ph = 0; ph < 5; ph++) begin
      write_weight(CFG_COUNT_WEIGHT, wc[ph]);
      write_weight(CFG_TIME_WEIGHT, wt[ph]);
      case (ph)
        0: random_phase(260, 0, 0);
        1: random_phase(260, 60, 0);
        2: random_phase(260, 0, 60);
        3: random_phase(260, 11, 11);
        default: random_phase(220, 0, 0);
      endcase
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
